// File: hw/rtl/i2c_master_byte_engine_top_defines.svh
// ---------------------------------------------------------------------------
// i2c_master_byte_engine_top_defines
// Assertion macros shared by the I2C master byte engine RTL.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define MBE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/i2c_mbe_pkg.sv
// ---------------------------------------------------------------------------
// i2c_mbe_pkg
// Types and constants for the I2C master byte engine.
// ---------------------------------------------------------------------------
package i2c_mbe_pkg;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [7:0]  MSB_MASK       = 8'h80;
    localparam logic [3:0]  BITS_PER_BYTE  = 4'd8;
    localparam logic [15:0] HALF_PERIOD_RST = 16'd10;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_SEQ_A   = 4'd1,
        PH_SEQ_B   = 4'd2,
        PH_SEQ_C   = 4'd3,
        PH_W_DATA  = 4'd4,
        PH_W_HIGH  = 4'd5,
        PH_W_LOW   = 4'd6,
        PH_WA_REL  = 4'd7,
        PH_WA_HIGH = 4'd8,
        PH_WA_LOW  = 4'd9,
        PH_R_HIGH  = 4'd10,
        PH_R_LOW   = 4'd11,
        PH_RA_HIGH = 4'd12,
        PH_RA_LOW  = 4'd13
    } phase_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_bit;
    } out_item_t;

endpackage

// File: hw/rtl/i2c_mbe_core.sv
// ---------------------------------------------------------------------------
// i2c_mbe_core
// Bus phase sequencer: holds the engine state, advances it by one tick per
// strobe and presents the resulting pin drive and status word.
// ---------------------------------------------------------------------------
`include "i2c_master_byte_engine_top_defines.svh"

module i2c_mbe_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  i2c_mbe_pkg::in_item_t item,
    input  logic [15:0]           half_period,
    output i2c_mbe_pkg::out_item_t res
);
    import i2c_mbe_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [15:0] tick_reg, tick_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  rx_reg, rx_next;
    logic        ack_reg, ack_next;
    logic        nack_reg, nack_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;

    logic [15:0] hp;
    logic [16:0] tick_inc;
    logic        is_idle;
    logic        phase_end;
    logic        cmd_ok;
    logic [3:0]  bit_inc;
    logic        more_bits;

    // zero period behaves as one tick
    assign hp        = (half_period == 16'd0) ? 16'd1 : half_period;
    assign tick_inc  = {1'b0, tick_reg} + 17'd1;
    assign is_idle   = (phase_reg == PH_IDLE);
    assign phase_end = !is_idle && (tick_inc >= {1'b0, hp});
    assign bit_inc   = bit_reg + 4'd1;
    assign more_bits = (bit_inc < BITS_PER_BYTE);

    always_comb
    begin
        case (item.op)
            OP_START, OP_STOP, OP_WRITE, OP_READ: cmd_ok = 1'b1;
            default:                              cmd_ok = 1'b0;
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (adv)
        begin
            if (is_idle)
            begin
                if (cmd_ok)
                begin
                    case (item.op)
                        OP_START, OP_STOP: phase_next = PH_SEQ_A;
                        OP_WRITE:          phase_next = PH_W_DATA;
                        default:           phase_next = PH_R_HIGH;
                    endcase
                end
            end
            else if (phase_end)
            begin
                case (phase_reg)
                    PH_SEQ_A:   phase_next = PH_SEQ_B;
                    PH_SEQ_B:   phase_next = PH_SEQ_C;
                    PH_W_DATA:  phase_next = PH_W_HIGH;
                    PH_W_HIGH:  phase_next = PH_W_LOW;
                    PH_W_LOW:   phase_next = more_bits ? PH_W_DATA : PH_WA_REL;
                    PH_WA_REL:  phase_next = PH_WA_HIGH;
                    PH_WA_HIGH: phase_next = PH_WA_LOW;
                    PH_R_HIGH:  phase_next = PH_R_LOW;
                    PH_R_LOW:   phase_next = more_bits ? PH_R_HIGH : PH_RA_HIGH;
                    PH_RA_HIGH: phase_next = PH_RA_LOW;
                    default:    phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // datapath and pin levels
    always_comb
    begin
        cmd_next   = cmd_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        rx_next    = rx_reg;
        ack_next   = ack_reg;
        nack_next  = nack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        if (adv)
        begin
            if (is_idle)
            begin
                if (cmd_ok)
                begin
                    tick_next = 16'd0;
                    bit_next  = 4'd0;
                    cmd_next  = item.op;
                    case (item.op)
                        OP_START:
                        begin
                            sda_next = 1'b0;
                            scl_next = 1'b0;
                        end
                        OP_STOP:
                        begin
                            sda_next = 1'b1;
                        end
                        OP_WRITE:
                        begin
                            sda_next   = ((item.tx_byte & MSB_MASK) == 8'd0);
                            shift_next = {item.tx_byte[6:0], 1'b0};
                        end
                        default:
                        begin
                            nack_next  = item.send_nack;
                            shift_next = 8'd0;
                            sda_next   = 1'b0;
                            scl_next   = 1'b0;
                        end
                    endcase
                end
            end
            else if (phase_end)
            begin
                tick_next = 16'd0;
                case (phase_reg)
                    PH_SEQ_A:
                    begin
                        if (cmd_reg == OP_START)
                            sda_next = 1'b1;
                        else
                            scl_next = 1'b0;
                    end
                    PH_SEQ_B:
                    begin
                        if (cmd_reg == OP_START)
                            scl_next = 1'b1;
                        else
                            sda_next = 1'b0;
                    end
                    PH_W_DATA:  scl_next = 1'b0;
                    PH_W_HIGH:  scl_next = 1'b1;
                    PH_W_LOW:
                    begin
                        bit_next = bit_inc;
                        if (more_bits)
                        begin
                            sda_next   = ((shift_reg & MSB_MASK) == 8'd0);
                            shift_next = {shift_reg[6:0], 1'b0};
                        end
                        else
                        begin
                            sda_next = 1'b0;
                        end
                    end
                    PH_WA_REL:  scl_next = 1'b0;
                    PH_WA_HIGH:
                    begin
                        ack_next = item.sda_in;
                        scl_next = 1'b1;
                    end
                    PH_R_HIGH:
                    begin
                        shift_next = {shift_reg[6:0], item.sda_in};
                        scl_next   = 1'b1;
                    end
                    PH_R_LOW:
                    begin
                        bit_next = bit_inc;
                        scl_next = 1'b0;
                        if (!more_bits)
                        begin
                            rx_next  = shift_reg;
                            sda_next = !nack_reg;
                        end
                    end
                    PH_RA_HIGH: scl_next = 1'b1;
                    default:    cmd_next = OP_NONE;
                endcase
            end
            else
            begin
                tick_next = tick_inc[15:0];
            end
        end
    end

    always_comb
    begin
        res.scl_drive_low = scl_next;
        res.sda_drive_low = sda_next;
        res.busy_res      = (phase_next != PH_IDLE);
        res.done_res      = adv && phase_end && (phase_next == PH_IDLE);
        res.rx_byte       = rx_next;
        res.ack_bit       = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= OP_NONE;
            tick_reg  <= 16'd0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            rx_reg    <= 8'd0;
            ack_reg   <= 1'b1;
            nack_reg  <= 1'b0;
            scl_reg   <= 1'b0;
            sda_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            rx_reg    <= rx_next;
            ack_reg   <= ack_next;
            nack_reg  <= nack_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
        end
    end

    `MBE_ASSERT_NOW(a_done_not_busy, res.done_res, !res.busy_res, "done while still busy")
    `MBE_ASSERT_NOW(a_bit_range, 1'b1, bit_reg <= BITS_PER_BYTE, "bit index past byte end")
    `MBE_ASSERT_NEXT(a_idle_holds, is_idle && !adv, phase_reg == PH_IDLE, "left idle without a tick")

endmodule

// File: hw/rtl/i2c_master_byte_engine_top.sv
// ---------------------------------------------------------------------------
// i2c_master_byte_engine_top
// Open-drain I2C master stepped one tick per input word.
// ---------------------------------------------------------------------------
// Each input word is one tick: a command (start, stop, write byte, read
// byte) plus the SDA sample for that tick; each one yields exactly one
// output word with the pin drive, busy/done flags, last read byte and last
// write ACK. One word is taken every clock while out_ready is high: the tick
// passes an input register, one pass of the phase sequencer, and an output
// register, where the word's result is presented and can be taken when
// out_ready is high. Throughput drops only when out_ready is held low. The
// half-period register is to be written through cfg_valid/cfg_data only while
// no tick word is in flight; the block itself does not enforce this.
`include "i2c_master_byte_engine_top_defines.svh"

module i2c_master_byte_engine_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  i2c_mbe_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output i2c_mbe_pkg::out_item_t out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            cfg_data
);
    import i2c_mbe_pkg::*;

    logic        in_valid_reg;
    in_item_t    in_data_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    logic [15:0] half_period_reg;
    logic        adv;
    out_item_t   step_res;

    // move the held tick into the output stage when that stage frees up
    assign adv       = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    i2c_mbe_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .item        (in_data_reg),
        .half_period (half_period_reg),
        .res         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_period_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= step_res;
        end
    end

    `MBE_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_reg, "stepped word not presented")
    `MBE_ASSERT_NEXT(a_held_tick_kept, in_valid_reg && !adv, in_valid_reg && $stable(in_data_reg), "held tick lost")
    `MBE_ASSERT_NOW(a_in_ready_when_free, !in_valid_reg, in_ready, "input stage empty but not ready")

endmodule

// File: tb/i2c_bus_checker.sv
// ----------------------------------------------------------------------------
// i2c_bus_checker
// Watches the tick, result and period channels of the I2C master byte engine,
// runs its own model of the bus sequencer on every accepted tick word and
// compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module i2c_bus_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  i2c_mbe_pkg::in_item_t  in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  i2c_mbe_pkg::out_item_t out_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [15:0]            cfg_data,
    output int                     fail_count,
    output int                     words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import i2c_mbe_pkg::*;

    localparam int SHOW_MAX = 10;

    // model of the engine
    logic [15:0] half_period;
    phase_t      phase;
    logic [2:0]  cmd;
    logic [15:0] tick_cnt;
    logic [3:0]  bit_idx;
    logic [7:0]  shreg;
    logic [7:0]  rx_hold;
    logic        ack_hold;
    logic        nack_req;
    logic        scl_low;
    logic        sda_low;

    out_item_t   bus_due_q[$];
    out_item_t   want;
    int          result_cnt;

    function automatic void shift_out_msb();
        sda_low = ((shreg & MSB_MASK) == 8'h00);
        shreg   = shreg << 1;
    endfunction

    // one tick of the sequencer; returns the pin/flag word it produces
    function automatic out_item_t step_bus(input in_item_t w);
        logic [15:0] span;
        logic [16:0] nxt;
        logic        fin;
        out_item_t   r;
        span = (half_period == 16'd0) ? 16'd1 : half_period;
        fin  = 1'b0;
        if (phase == PH_IDLE) begin
            if (w.op == OP_START || w.op == OP_STOP || w.op == OP_WRITE || w.op == OP_READ)
            begin
                tick_cnt = 16'd0;
                bit_idx  = 4'd0;
                cmd      = w.op;
                case (w.op)
                    OP_START:
                    begin
                        sda_low = 1'b0;
                        scl_low = 1'b0;
                        phase   = PH_SEQ_A;
                    end
                    OP_STOP:
                    begin
                        sda_low = 1'b1;
                        phase   = PH_SEQ_A;
                    end
                    OP_WRITE:
                    begin
                        shreg = w.tx_byte;
                        shift_out_msb();
                        phase = PH_W_DATA;
                    end
                    default:
                    begin
                        nack_req = w.send_nack;
                        shreg    = 8'h00;
                        sda_low  = 1'b0;
                        scl_low  = 1'b0;
                        phase    = PH_R_HIGH;
                    end
                endcase
            end
        end
        else
        begin
            nxt = {1'b0, tick_cnt} + 17'd1;
            if (nxt >= {1'b0, span}) begin
                tick_cnt = 16'd0;
                case (phase)
                    PH_SEQ_A:
                    begin
                        if (cmd == OP_START) sda_low = 1'b1;
                        else scl_low = 1'b0;
                        phase = PH_SEQ_B;
                    end
                    PH_SEQ_B:
                    begin
                        if (cmd == OP_START) scl_low = 1'b1;
                        else sda_low = 1'b0;
                        phase = PH_SEQ_C;
                    end
                    PH_W_DATA:
                    begin
                        scl_low = 1'b0;
                        phase   = PH_W_HIGH;
                    end
                    PH_W_HIGH:
                    begin
                        scl_low = 1'b1;
                        phase   = PH_W_LOW;
                    end
                    PH_W_LOW:
                    begin
                        bit_idx = bit_idx + 4'd1;
                        if (bit_idx < BITS_PER_BYTE) begin
                            shift_out_msb();
                            phase = PH_W_DATA;
                        end
                        else
                        begin
                            sda_low = 1'b0;
                            phase   = PH_WA_REL;
                        end
                    end
                    PH_WA_REL:
                    begin
                        scl_low = 1'b0;
                        phase   = PH_WA_HIGH;
                    end
                    PH_WA_HIGH:
                    begin
                        ack_hold = w.sda_in;
                        scl_low  = 1'b1;
                        phase    = PH_WA_LOW;
                    end
                    PH_R_HIGH:
                    begin
                        shreg   = {shreg[6:0], w.sda_in};
                        scl_low = 1'b1;
                        phase   = PH_R_LOW;
                    end
                    PH_R_LOW:
                    begin
                        bit_idx = bit_idx + 4'd1;
                        if (bit_idx < BITS_PER_BYTE) begin
                            scl_low = 1'b0;
                            phase   = PH_R_HIGH;
                        end
                        else
                        begin
                            rx_hold = shreg;
                            sda_low = !nack_req;
                            scl_low = 1'b0;
                            phase   = PH_RA_HIGH;
                        end
                    end
                    PH_RA_HIGH:
                    begin
                        scl_low = 1'b1;
                        phase   = PH_RA_LOW;
                    end
                    default:
                    begin
                        // trailing phase of every command
                        phase = PH_IDLE;
                        cmd   = OP_NONE;
                        fin   = 1'b1;
                    end
                endcase
            end
            else
            begin
                tick_cnt = nxt[15:0];
            end
        end
        r.scl_drive_low = scl_low;
        r.sda_drive_low = sda_low;
        r.busy_res      = (phase != PH_IDLE);
        r.done_res      = fin;
        r.rx_byte       = rx_hold;
        r.ack_bit       = ack_hold;
        return r;
    endfunction

    function automatic void note_fail(input string why, input out_item_t w,
                                      input out_item_t g);
        if (fail_count < SHOW_MAX)
            $display("%0t: result %0d %s: want scl=%b sda=%b busy=%b done=%b rx=%h ack=%b, got scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                     $realtime, result_cnt, why,
                     w.scl_drive_low, w.sda_drive_low, w.busy_res, w.done_res,
                     w.rx_byte, w.ack_bit,
                     g.scl_drive_low, g.sda_drive_low, g.busy_res, g.done_res,
                     g.rx_byte, g.ack_bit);
        fail_count = fail_count + 1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            half_period = HALF_PERIOD_RST;
            phase       = PH_IDLE;
            cmd         = OP_NONE;
            tick_cnt    = 16'd0;
            bit_idx     = 4'd0;
            shreg       = 8'h00;
            rx_hold     = 8'h00;
            ack_hold    = 1'b1;
            nack_req    = 1'b0;
            scl_low     = 1'b0;
            sda_low     = 1'b0;
            bus_due_q.delete();
            fail_count  = 0;
            words_due   = 0;
            result_cnt  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                half_period = cfg_data;
            if (in_valid && in_ready)
                bus_due_q.push_back(step_bus(in_data));
            if (out_valid && out_ready) begin
                if (bus_due_q.size() == 0) begin
                    note_fail("with nothing pending", '0, out_data);
                end
                else
                begin
                    want = bus_due_q.pop_front();
                    if (out_data.scl_drive_low !== want.scl_drive_low ||
                        out_data.sda_drive_low !== want.sda_drive_low ||
                        out_data.busy_res      !== want.busy_res      ||
                        out_data.done_res      !== want.done_res      ||
                        out_data.rx_byte       !== want.rx_byte       ||
                        out_data.ack_bit       !== want.ack_bit)
                        note_fail("mismatch", want, out_data);
                end
                result_cnt = result_cnt + 1;
            end
            words_due = bus_due_q.size();
        end
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the I2C master byte engine with tick words: directed commands at the
// period extremes, then random command streams under several idle and stall
// mixes, while i2c_bus_checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import i2c_mbe_pkg::*;

    localparam logic [2:0] OP_RSVD_LO    = 3'd5;
    localparam logic [2:0] OP_RSVD_HI    = 3'd7;
    localparam int         FRAME_PHASES  = 3;
    localparam int         WRITE_PHASES  = 27;
    localparam int         READ_PHASES   = 18;
    localparam int         SDA_LOW       = 0;
    localparam int         SDA_HIGH      = 1;
    localparam int         SDA_RAND      = 2;
    localparam int         RAND_TICKS    = 60;
    localparam int         CYCLE_LIMIT   = 300000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'd0;

    int          fail_count;
    int          words_due;
    int          send_pct = 0;
    int          stall_pct = 0;
    int          cycles = 0;
    logic [15:0] cur_period = HALF_PERIOD_RST;

    int send_mix[4]   = '{0, 69, 0, 10};
    int stall_mix[4]  = '{0, 0, 69, 10};
    int period_mix[4] = '{1, 2, 1, 3};

    always #5 clk = ~clk;

    i2c_master_byte_engine_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    i2c_bus_checker bus_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic pick_sda(input int sel);
        if (sel == SDA_LOW) return 1'b0;
        if (sel == SDA_HIGH) return 1'b1;
        return 1'($urandom_range(1, 0));
    endfunction

    function automatic in_item_t make_word(input logic [2:0] op, input logic [7:0] data,
                                           input logic nack, input int sda_sel);
        in_item_t w;
        w.op        = op;
        w.tx_byte   = data;
        w.send_nack = nack;
        w.sda_in    = pick_sda(sda_sel);
        return w;
    endfunction

    // ticks a command stays busy after the word that starts it
    function automatic int cmd_ticks(input logic [2:0] op);
        int span;
        span = (cur_period == 16'd0) ? 1 : cur_period;
        case (op)
            OP_START, OP_STOP: return FRAME_PHASES * span;
            OP_WRITE:          return WRITE_PHASES * span;
            OP_READ:           return READ_PHASES * span;
            default:           return 0;
        endcase
    endfunction

    // all tasks below start and end on a falling edge
    task automatic send_word(input in_item_t w);
        if ($urandom_range(99) < send_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_pct) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // random opcodes: these land while the engine is busy and must be dropped
    task automatic send_filler(input int n, input int sda_sel);
        repeat (n) send_word(make_word(3'($urandom), 8'($urandom), 1'($urandom), sda_sel));
    endtask

    task automatic run_cmd(input logic [2:0] op, input logic [7:0] data, input logic nack,
                           input int sda_sel, input int fill);
        send_word(make_word(op, data, nack, sda_sel));
        send_filler(fill, sda_sel);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (words_due != 0) @(negedge clk);
    endtask

    task automatic set_period(input logic [15:0] v);
        cfg_valid  <= 1'b1;
        cfg_data   <= v;
        cur_period = v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int         used;
        int         fill;
        int         k;
        int         m;
        logic [2:0] op_sel;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset period
        run_cmd(OP_START, 8'h00, 1'b0, SDA_RAND, cmd_ticks(OP_START));
        drain_results();
        set_period(16'd1);

        // undefined opcodes while idle
        send_word(make_word(OP_NONE, 8'hFF, 1'b1, SDA_HIGH));
        send_word(make_word(OP_RSVD_LO, 8'($urandom), 1'b0, SDA_LOW));
        send_word(make_word(OP_RSVD_LO + 3'd1, 8'($urandom), 1'b1, SDA_RAND));
        send_word(make_word(OP_RSVD_HI, 8'($urandom), 1'b0, SDA_RAND));

        run_cmd(OP_WRITE, 8'h00, 1'b0, SDA_LOW, cmd_ticks(OP_WRITE));
        run_cmd(OP_WRITE, 8'hFF, 1'b1, SDA_HIGH, cmd_ticks(OP_WRITE));
        run_cmd(OP_READ, 8'h00, 1'b0, SDA_HIGH, cmd_ticks(OP_READ));
        run_cmd(OP_READ, 8'hFF, 1'b1, SDA_LOW, cmd_ticks(OP_READ));
        run_cmd(OP_STOP, 8'($urandom), 1'b0, SDA_RAND, cmd_ticks(OP_STOP));

        // zero period behaves as one tick
        drain_results();
        set_period(16'd0);
        run_cmd(OP_WRITE, 8'hA5, 1'b0, SDA_RAND, cmd_ticks(OP_WRITE));

        // longest period, cut short mid phase by a smaller one
        drain_results();
        set_period(16'hFFFF);
        run_cmd(OP_WRITE, 8'h3C, 1'b1, SDA_RAND, 40);
        drain_results();
        set_period(16'd2);
        // stale count ends the current phase on the next tick
        send_filler(1 + (WRITE_PHASES - 1) * 2, SDA_RAND);

        for (m = 0; m < 4; m++) begin
            drain_results();
            set_period(16'(period_mix[m]));
            send_pct  = send_mix[m];
            stall_pct = stall_mix[m];
            used = 0;
            while (used < RAND_TICKS) begin
                k = $urandom_range(99);
                if (k < 12) begin
                    op_sel = 3'($urandom_range(OP_RSVD_HI, OP_READ));
                    if (op_sel == OP_READ) op_sel = OP_NONE;
                    send_word(make_word(op_sel, 8'($urandom), 1'($urandom), SDA_RAND));
                    used = used + 1;
                end
                else
                begin
                    op_sel = 3'($urandom_range(OP_READ, OP_START));
                    fill = cmd_ticks(op_sel);
                    // broken sequence: next command lands while still busy
                    if (k < 20) fill = $urandom_range(fill - 1, 0);
                    run_cmd(op_sel, 8'($urandom), 1'($urandom), SDA_RAND, fill);
                    used = used + fill + 1;
                end
            end
        end

        drain_results();
        repeat (6) @(negedge clk);
        if (fail_count == 0 && words_due == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/i2c_mbe_pkg.sv
hw/rtl/i2c_mbe_core.sv
hw/rtl/i2c_master_byte_engine_top.sv
tb/i2c_bus_checker.sv
tb/testbench.sv
